// ===== design/sha256_byte_stream_hasher_assert.svh =====
// assertion macros for the sha-256 byte stream hasher
// used by the port checker; no other dependencies
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// clocked check, masked while reset is held
`define SHA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked check that also runs through reset
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== design/sha256_pkg.sv =====
// shared types, constants and sigma functions for the sha-256 hasher
// no dependencies
`timescale 1ns / 1ps

package sha256_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [7:0]       byte_t;
  typedef logic [7:0][31:0] digest_t;
  typedef logic [5:0]       round_idx_t;
  typedef logic [2:0]       word_idx_t;

  localparam int unsigned NUM_ROUNDS = 64;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BLOCK_BITS = 8 * BLOCK_BYTES;

  localparam byte_t      PAD_MARK_BYTE = 8'h80;
  localparam byte_t      PAD_ZERO_BYTE = 8'h00;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] FILL_LEN_START = 6'd56;
  localparam round_idx_t ROUND_LAST = 6'd63;
  localparam word_idx_t  WORD_LAST = 3'd7;
  localparam logic [63:0] BLOCK_BIT_COUNT = 64'd512;

  // initial hash value, index 0 is the first word
  localparam digest_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // control from the sequencer to the message window
  typedef struct packed {
    logic  shift_byte;
    logic  shift_word;
    byte_t byte_val;
  } sched_ctl_t;

  // control from the sequencer to the round unit
  typedef struct packed {
    logic       init;
    logic       step;
    logic       fold;
    logic       restart;
    round_idx_t round;
  } round_ctl_t;

  function automatic word_t big_sigma0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== design/sha256_if.sv =====
// valid/ready channel interfaces: message byte input and digest word output
// depends on sha256_pkg
`timescale 1ns / 1ps

interface sha256_in_if import sha256_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  byte_present;
  logic  message_end;

  modport source (output valid, output data_byte, output byte_present,
                  output message_end, input ready);
  modport sink (input valid, input data_byte, input byte_present,
                input message_end, output ready);
endinterface

interface sha256_out_if import sha256_pkg::*; ();
  logic      valid;
  logic      ready;
  word_t     digest_word;
  word_idx_t word_index;
  logic      last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

// ===== design/sha256_sched.sv =====
// message window: collects block bytes and expands the message schedule
// depends on sha256_pkg
`timescale 1ns / 1ps

module sha256_sched import sha256_pkg::*; (
  input  logic       clk,
  input  sched_ctl_t ctl,
  output word_t      w_cur
);

  // word i of the window sits at bits [BLOCK_BITS-1-32*i -: 32]
  logic [BLOCK_BITS-1:0] win_r;
  word_t                 w_new;

  assign w_cur = win_r[BLOCK_BITS-1 -: 32];

  always_comb begin
    w_new = small_sigma1(win_r[BLOCK_BITS-1-32*14 -: 32])
          + win_r[BLOCK_BITS-1-32*9 -: 32]
          + small_sigma0(win_r[BLOCK_BITS-1-32*1 -: 32])
          + win_r[BLOCK_BITS-1 -: 32];
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      win_r <= {win_r[BLOCK_BITS-9:0], ctl.byte_val};
    end else if (ctl.shift_word) begin
      win_r <= {win_r[BLOCK_BITS-33:0], w_new};
    end
  end

endmodule

// ===== design/sha256_round.sv =====
// shared round unit: one compression round per cycle plus chaining words
// depends on sha256_pkg
`timescale 1ns / 1ps

module sha256_round import sha256_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  round_ctl_t ctl,
  input  word_t      w_cur,
  output digest_t    chain
);

  digest_t chain_r;
  digest_t work_r;
  word_t   t1;
  word_t   t2;
  word_t   ch;
  word_t   maj;

  assign chain = chain_r;

  always_comb begin
    ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
    maj = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
    t1  = work_r[7] + big_sigma1(work_r[4]) + ch + ROUND_K[ctl.round] + w_cur;
    t2  = big_sigma0(work_r[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= INIT_HASH;
    end else if (ctl.restart) begin
      chain_r <= INIT_HASH;
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= chain_r[i] + work_r[i];
      end
    end
  end

  // working variables a..h at index 0..7
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      work_r <= chain_r;
    end else if (ctl.step) begin
      work_r <= {work_r[6], work_r[5], work_r[4], work_r[3] + t1,
                 work_r[2], work_r[1], work_r[0], t1 + t2};
    end
  end

endmodule

// ===== design/sha256_digest_out.sv =====
// digest output buffer: holds eight words and hands them out one per beat
// depends on sha256_pkg and sha256_out_if
`timescale 1ns / 1ps

module sha256_digest_out import sha256_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  digest_t             digest,
  output logic                busy,
  sha256_out_if.source        out_ch
);

  digest_t   buf_r;
  word_idx_t idx_r;
  logic      valid_r;
  logic      beat;

  assign beat               = valid_r && out_ch.ready;
  assign busy               = valid_r;
  assign out_ch.valid       = valid_r;
  assign out_ch.digest_word = buf_r[0];
  assign out_ch.word_index  = idx_r;
  assign out_ch.last_word   = (idx_r == WORD_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (beat) begin
      valid_r <= (idx_r != WORD_LAST);
      idx_r   <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= digest;
    end else if (beat) begin
      buf_r <= {32'h0, buf_r[7:1]};
    end
  end

endmodule

// ===== design/sha256_byte_stream_hasher.sv =====
// message bytes are taken one per beat while a block fills; the beat that fills a block
// closes the input for a compression (load, 64 rounds on the shared round unit, fold)
// end of message: mark, zero and length pad bytes and one or two compressions, then 8 word beats
// the input stays closed while a block compresses, while padding runs and until the handover
// the input reopens as soon as the digest sits in the output buffer
// reset (synchronous, rst_n low): initial hash words, zero length, empty block, no output
`timescale 1ns / 1ps

module sha256_byte_stream_hasher import sha256_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_MARK,
    S_PAD_ZERO,
    S_PAD_LEN,
    S_COMP_INIT,
    S_COMP_RUN,
    S_COMP_FOLD,
    S_FINAL
  } state_t;

  state_t      state_r, state_nxt;
  state_t      ret_r, ret_nxt;       // where to go after a compression
  logic [5:0]  fill_r, fill_nxt;     // bytes in the current block
  logic [63:0] bits_done_r, bits_done_nxt;
  logic [63:0] len_r, len_nxt;       // message bit length, shifted out msb first
  round_idx_t  round_r, round_nxt;

  sched_ctl_t  sched_ctl;
  round_ctl_t  round_ctl;
  word_t       w_cur;
  digest_t     chain;
  logic        out_busy;
  logic        out_load;
  logic        in_beat;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    fill_nxt      = fill_r;
    bits_done_nxt = bits_done_r;
    len_nxt       = len_r;
    round_nxt     = round_r;

    sched_ctl     = '0;
    round_ctl     = '0;
    round_ctl.round = round_r;
    out_load      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          if (in_ch.byte_present) begin
            sched_ctl.shift_byte = 1'b1;
            sched_ctl.byte_val   = in_ch.data_byte;
            if (fill_r == FILL_LAST) begin
              // message byte completes a block
              fill_nxt      = '0;
              bits_done_nxt = bits_done_r + BLOCK_BIT_COUNT;
              ret_nxt       = in_ch.message_end ? S_PAD_MARK : S_IDLE;
              state_nxt     = S_COMP_INIT;
            end else begin
              fill_nxt = fill_r + 6'd1;
              if (in_ch.message_end) begin
                state_nxt = S_PAD_MARK;
              end
            end
          end else if (in_ch.message_end) begin
            state_nxt = S_PAD_MARK;
          end
        end
      end

      S_PAD_MARK: begin
        sched_ctl.shift_byte = 1'b1;
        sched_ctl.byte_val   = PAD_MARK_BYTE;
        // total length wraps modulo 2^64
        len_nxt = bits_done_r + {55'd0, fill_r, 3'd0};
        if (fill_r == FILL_LAST) begin
          fill_nxt  = '0;
          ret_nxt   = S_PAD_ZERO;
          state_nxt = S_COMP_INIT;
        end else begin
          fill_nxt  = fill_r + 6'd1;
          state_nxt = S_PAD_ZERO;
        end
      end

      S_PAD_ZERO: begin
        if (fill_r == FILL_LEN_START) begin
          state_nxt = S_PAD_LEN;
        end else begin
          sched_ctl.shift_byte = 1'b1;
          sched_ctl.byte_val   = PAD_ZERO_BYTE;
          if (fill_r == FILL_LAST) begin
            // length does not fit, close this block and pad another
            fill_nxt  = '0;
            ret_nxt   = S_PAD_ZERO;
            state_nxt = S_COMP_INIT;
          end else begin
            fill_nxt = fill_r + 6'd1;
          end
        end
      end

      S_PAD_LEN: begin
        sched_ctl.shift_byte = 1'b1;
        sched_ctl.byte_val   = len_r[63:56];
        len_nxt              = {len_r[55:0], 8'h00};
        if (fill_r == FILL_LAST) begin
          fill_nxt  = '0;
          ret_nxt   = S_FINAL;
          state_nxt = S_COMP_INIT;
        end else begin
          fill_nxt = fill_r + 6'd1;
        end
      end

      S_COMP_INIT: begin
        round_ctl.init = 1'b1;
        round_nxt      = '0;
        state_nxt      = S_COMP_RUN;
      end

      S_COMP_RUN: begin
        round_ctl.step       = 1'b1;
        sched_ctl.shift_word = 1'b1;
        round_nxt            = round_r + 6'd1;
        if (round_r == ROUND_LAST) begin
          state_nxt = S_COMP_FOLD;
        end
      end

      S_COMP_FOLD: begin
        round_ctl.fold = 1'b1;
        state_nxt      = ret_r;
      end

      S_FINAL: begin
        // wait for the previous digest to drain, then hand over and start over
        if (!out_busy) begin
          out_load          = 1'b1;
          round_ctl.restart = 1'b1;
          bits_done_nxt     = '0;
          fill_nxt          = '0;
          state_nxt         = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      fill_r      <= '0;
      bits_done_r <= '0;
      round_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      fill_r      <= fill_nxt;
      bits_done_r <= bits_done_nxt;
      round_r     <= round_nxt;
    end
    len_r <= len_nxt;
  end

  // block window and schedule expansion
  sha256_sched u_sched (
    .clk   (clk),
    .ctl   (sched_ctl),
    .w_cur (w_cur)
  );

  // shared round unit with the chaining words
  sha256_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (round_ctl),
    .w_cur (w_cur),
    .chain (chain)
  );

  // digest buffer toward the result channel
  sha256_digest_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (out_load),
    .digest (chain),
    .busy   (out_busy),
    .out_ch (out_ch)
  );

endmodule

// ===== design/sha256_checker.sv =====
// port checker for the sha-256 byte stream hasher, bound to the top level
// depends on sha256_pkg and sha256_byte_stream_hasher_assert.svh
`timescale 1ns / 1ps
`include "sha256_byte_stream_hasher_assert.svh"

module sha256_checker import sha256_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input word_idx_t out_word_index,
  input logic      out_last_word
);

  // a pending word holds until taken
  `SHA_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "out valid dropped")

  // digest words come out in order without gaps
  `SHA_ASSERT(a_out_order, clk, rst_n, (out_valid && out_ready && !out_last_word) |=> (out_valid && (out_word_index == $past(out_word_index) + 3'd1)), "digest word order broken")

  // last flag marks word seven only
  `SHA_ASSERT(a_out_last, clk, rst_n, out_valid |-> (out_last_word == (out_word_index == WORD_LAST)), "last word flag wrong")

  // a new digest starts only after the previous one drained, while input is held
  `SHA_ASSERT(a_out_start, clk, rst_n, (out_valid && out_ready && out_last_word) |=> !out_valid, "digest overlap")
  `SHA_ASSERT(a_out_rise, clk, rst_n, $rose(out_valid) |-> ($past(!in_ready) && (out_word_index == 3'd0)), "digest started while input open")

endmodule

bind sha256_byte_stream_hasher sha256_checker u_sha256_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_word_index (out_ch.word_index),
  .out_last_word  (out_ch.last_word)
);
